>>> rtl/core/coalescing_event_queue_unit_macros.svh
// assertion helpers shared by the queue rtl
`ifndef COALESCING_EVENT_QUEUE_UNIT_MACROS_SVH
`define COALESCING_EVENT_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define CEVQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define CEVQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/cevq_pkg.sv
package cevq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // request modes
  localparam logic [1:0] MODE_POST  = 2'd0;
  localparam logic [1:0] MODE_FOLD  = 2'd1;
  localparam logic [1:0] MODE_POP   = 2'd2;
  localparam logic [1:0] MODE_PURGE = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_BUSY  = 2'd3;

  // one stored event
  typedef struct packed {
    logic [31:0] etype;
    logic [15:0] target;
    logic [31:0] payload;
  } slot_t;

  // slot memory write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } ram_wr_t;

  // slot memory read port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

  // one result before the output register
  typedef struct packed {
    logic             kind;
    logic [1:0]       status;
    slot_t            evt;
    logic [CNT_W-1:0] removed;
    logic             last;
  } result_t;

  // circular slot index increment
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return idx + 1'b1;
  endfunction

endpackage

>>> rtl/core/cevq_if.sv
// request channel
interface cevq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] event_type;
  logic [15:0] event_target;
  logic [31:0] event_payload;
  logic        wait_flag;

  modport source (
    output valid, mode, event_type, event_target, event_payload, wait_flag,
    input  ready
  );
  modport sink (
    input  valid, mode, event_type, event_target, event_payload, wait_flag,
    output ready
  );
endinterface

// result channel
interface cevq_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [1:0]  status;
  logic [31:0] popped_type;
  logic [15:0] popped_target;
  logic [31:0] popped_payload;
  logic [4:0]  removed_count;
  logic [4:0]  pending_count;
  logic        last_result;

  modport source (
    output valid, result_kind, status, popped_type, popped_target, popped_payload,
           removed_count, pending_count, last_result,
    input  ready
  );
  modport sink (
    input  valid, result_kind, status, popped_type, popped_target, popped_payload,
           removed_count, pending_count, last_result,
    output ready
  );
endinterface

>>> rtl/core/cevq_slot_ram.sv
module cevq_slot_ram (
  input  logic              clk,
  input  cevq_pkg::ram_wr_t wr,
  input  cevq_pkg::ram_rd_t rd,
  output cevq_pkg::slot_t   rd_data
);

  cevq_pkg::slot_t mem [cevq_pkg::QUEUE_DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

>>> rtl/core/coalescing_event_queue_unit.sv
// Coalescing event queue: a bounded FIFO of up to 16 events (type, target,
// payload) held in a circular slot memory with one read and one write port.
// A request is taken only while the controller is idle; its results leave
// through an output register, so a new request may be taken while a result
// still waits. Fold scans the pending events oldest first, one slot per cycle
// through the memory read port, and stops at the first match or after all
// pending slots. Purge with a nonzero target reads and compacts every pending
// slot, one per cycle. An insert while a pop is held yields two results, an
// acknowledgement and then the delivered event.
`include "coalescing_event_queue_unit_macros.svh"

module coalescing_event_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  cevq_req_if.sink    req,
  cevq_rsp_if.source  rsp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INSERT = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_PURGE  = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  localparam int IW = cevq_pkg::IDX_W;
  localparam int CW = cevq_pkg::CNT_W;

  logic [2:0]              state;
  logic [31:0]             timer_code;
  logic [IW-1:0]           head;
  logic [IW-1:0]           tail;
  logic [CW-1:0]           count;
  logic                    pop_waiting;
  logic [IW-1:0]           rp;
  logic [IW-1:0]           wp;
  logic [IW-1:0]           scan_idx;
  logic [CW-1:0]           removed;
  logic                    dlv_pend;
  cevq_pkg::slot_t         req_evt;
  cevq_pkg::result_t       res;
  logic                    out_valid;
  cevq_pkg::result_t       out_res;
  logic [CW-1:0]           out_pending;

  cevq_pkg::ram_wr_t       wr;
  cevq_pkg::ram_rd_t       rd;
  cevq_pkg::slot_t         rdata;

  logic                    slot_free;
  logic                    fold_hit;
  logic                    purge_hit;
  logic                    last_scan;
  logic [CW-1:0]           removed_next;
  logic                    full;
  logic                    needs_read;
  logic [1:0]              start_status;
  logic [CW:0]             tail_sum;
  logic [CW:0]             tail_calc;

  cevq_slot_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rdata)
  );

  assign req.ready = (state == S_IDLE);

  // output register drives the result channel
  assign rsp.valid          = out_valid;
  assign rsp.result_kind    = out_res.kind;
  assign rsp.status         = out_res.status;
  assign rsp.popped_type    = out_res.evt.etype;
  assign rsp.popped_target  = out_res.evt.target;
  assign rsp.popped_payload = out_res.evt.payload;
  assign rsp.removed_count  = 5'(out_res.removed);
  assign rsp.pending_count  = 5'(out_pending);
  assign rsp.last_result    = out_res.last;

  // scan compares and status
  always_comb begin
    slot_free    = !out_valid || rsp.ready;
    fold_hit     = (rdata.etype == req_evt.etype) && (rdata.target == req_evt.target);
    purge_hit    = (rdata.target == req_evt.target);
    last_scan    = ((CW'(scan_idx) + 1'b1) == count);
    removed_next = removed + CW'(purge_hit);
    full         = (count == CW'(cevq_pkg::QUEUE_DEPTH));
    needs_read   = (count != '0) &&
                   ((req.mode == cevq_pkg::MODE_FOLD) || (req.mode == cevq_pkg::MODE_POP) ||
                    ((req.mode == cevq_pkg::MODE_PURGE) && (req.event_target != '0)));
    start_status = cevq_pkg::STATUS_OK;
    if ((req.mode == cevq_pkg::MODE_POP) && (count == '0)) begin
      if (!req.wait_flag) begin
        start_status = cevq_pkg::STATUS_EMPTY;
      end else if (pop_waiting) begin
        start_status = cevq_pkg::STATUS_BUSY;
      end
    end
  end

  // slot memory port control
  always_comb begin
    rd = '0;
    wr = '0;
    case (state)
      S_IDLE: begin
        if (req.valid && needs_read) begin
          rd.en   = 1'b1;
          rd.addr = head;
        end
      end
      S_SCAN: begin
        if (fold_hit) begin
          wr.en                = 1'b1;
          wr.addr              = rp;
          wr.data.etype        = rdata.etype;
          wr.data.target       = rdata.target;
          wr.data.payload      = (rdata.etype == timer_code) ?
                                 rdata.payload + 32'd1 : req_evt.payload;
        end else if (!last_scan) begin
          rd.en   = 1'b1;
          rd.addr = cevq_pkg::idx_inc(rp);
        end
      end
      S_PURGE: begin
        if (!purge_hit) begin
          wr.en   = 1'b1;
          wr.addr = wp;
          wr.data = rdata;
        end
        if (!last_scan) begin
          rd.en   = 1'b1;
          rd.addr = cevq_pkg::idx_inc(rp);
        end
      end
      S_INSERT: begin
        if (!pop_waiting && !full) begin
          wr.en   = 1'b1;
          wr.addr = tail;
          wr.data = req_evt;
        end
      end
      default: begin
      end
    endcase
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      timer_code  <= '0;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      pop_waiting <= 1'b0;
      dlv_pend    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timer_code <= cfg_wr_data;
      end
      if ((state == S_EMIT) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_evt.etype   <= req.event_type;
            req_evt.target  <= req.event_target;
            req_evt.payload <= req.event_payload;
            rp              <= head;
            wp              <= head;
            scan_idx        <= '0;
            removed         <= '0;
            res             <= '{kind: 1'b0, status: start_status, evt: '0,
                                 removed: '0, last: 1'b1};
            case (req.mode)
              cevq_pkg::MODE_POST: begin
                state <= S_INSERT;
              end
              cevq_pkg::MODE_FOLD: begin
                state <= (count == '0) ? S_INSERT : S_SCAN;
              end
              cevq_pkg::MODE_POP: begin
                if (count != '0) begin
                  state <= S_POP;
                end else begin
                  if (req.wait_flag && !pop_waiting) begin
                    pop_waiting <= 1'b1;
                  end
                  state <= S_EMIT;
                end
              end
              cevq_pkg::MODE_PURGE: begin
                state <= needs_read ? S_PURGE : S_EMIT;
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        // fold search, oldest first
        S_SCAN: begin
          if (fold_hit) begin
            state <= S_EMIT;
          end else if (last_scan) begin
            state <= S_INSERT;
          end else begin
            rp       <= cevq_pkg::idx_inc(rp);
            scan_idx <= scan_idx + 1'b1;
          end
        end
        // oldest event leaves at the head
        S_POP: begin
          res.kind <= 1'b1;
          res.evt  <= rdata;
          head     <= cevq_pkg::idx_inc(head);
          count    <= count - 1'b1;
          state    <= S_EMIT;
        end
        // compaction: kept slots move down behind the read pointer
        S_PURGE: begin
          if (!purge_hit) begin
            wp <= cevq_pkg::idx_inc(wp);
          end
          if (last_scan) begin
            count       <= count - removed_next;
            tail        <= purge_hit ? wp : cevq_pkg::idx_inc(wp);
            res.removed <= removed_next;
            state       <= S_EMIT;
          end else begin
            rp       <= cevq_pkg::idx_inc(rp);
            scan_idx <= scan_idx + 1'b1;
            removed  <= removed_next;
          end
        end
        // append, hand to a held pop, or report full
        S_INSERT: begin
          if (pop_waiting) begin
            pop_waiting <= 1'b0;
            res.last    <= 1'b0;
            dlv_pend    <= 1'b1;
          end else if (full) begin
            res.status <= cevq_pkg::STATUS_FULL;
          end else begin
            tail  <= cevq_pkg::idx_inc(tail);
            count <= count + 1'b1;
          end
          state <= S_EMIT;
        end
        // load the output register, then a held-pop delivery if any
        S_EMIT: begin
          if (slot_free) begin
            out_res     <= res;
            out_pending <= count;
            if (dlv_pend) begin
              dlv_pend    <= 1'b0;
              res.kind    <= 1'b1;
              res.status  <= cevq_pkg::STATUS_OK;
              res.evt     <= req_evt;
              res.removed <= '0;
              res.last    <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // expected tail from head and count
  always_comb begin
    tail_sum  = (CW + 1)'(head) + (CW + 1)'(count);
    tail_calc = (tail_sum >= (CW + 1)'(cevq_pkg::QUEUE_DEPTH)) ?
                tail_sum - (CW + 1)'(cevq_pkg::QUEUE_DEPTH) : tail_sum;
  end

  `CEVQ_ASSERT_IMPL(a_held_pop_empty, pop_waiting, count == '0, "held pop with events pending")
  `CEVQ_ASSERT_IMPL(a_tail_track, 1'b1, IW'(tail_calc) == tail, "tail out of step with head and count")
  `CEVQ_ASSERT_IMPL(a_idle_no_delivery, state == S_IDLE, !dlv_pend, "delivery left behind in idle")
  `CEVQ_ASSERT_NEXT(a_count_bound, 1'b1, count <= CW'(cevq_pkg::QUEUE_DEPTH), "count above depth")

endmodule
